// ===== design/bbm_pkg.sv =====
// ----------------------------------------------------------------------------
// bbm_pkg
// Shared widths, vector types and the Q2.14 output conversion for the
// billboard basis matrix pipeline.
// ----------------------------------------------------------------------------
package bbm_pkg;

  localparam int unsigned IN_W      = 32;  // input coordinate width
  localparam int unsigned UNIT_W    = 32;  // Q2.30 unit component
  localparam int unsigned WIDE_W    = 64;  // cross products, differences
  localparam int unsigned OUT_W     = 16;  // Q2.14 matrix element
  localparam int unsigned MAG_W     = 63;  // magnitude of a wide component
  localparam int unsigned NRM_W     = 30;  // magnitude after normalising shift
  localparam int unsigned POS_W     = 6;   // leading-one position in MAG_W bits
  localparam int unsigned SQ_W      = 62;  // sum of three squares
  localparam int unsigned ROOT_W    = 31;  // integer square root
  localparam int unsigned REM_W     = 35;  // square-root partial remainder
  localparam int unsigned DREM_W    = 32;  // divider partial remainder
  localparam int unsigned LOW_W     = 31;  // dividend bits still to shift in
  localparam int unsigned QUO_W     = 31;  // quotient, at most 2^30

  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned SQRT_PER   = 2;
  localparam int unsigned SQRT_STG   = (SQRT_STEPS + SQRT_PER - 1) / SQRT_PER;
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned DIV_PER    = 2;
  localparam int unsigned DIV_STG    = (DIV_STEPS + DIV_PER - 1) / DIV_PER;

  // abs, coarse search, fine search, shift, squares, sum, root stages, divider setup, divide stages, sign
  localparam int unsigned NORM_LAT  = 6 + SQRT_STG + 1 + DIV_STG + 1;
  localparam int unsigned CROSS_LAT = 2;

  localparam int unsigned ADDR_W   = 2;
  localparam int unsigned REG_MODE = 0;

  localparam logic signed [OUT_W-1:0] Q14_ONE = 16'sd16384;

  typedef struct packed {
    logic signed [UNIT_W-1:0] x;
    logic signed [UNIT_W-1:0] y;
    logic signed [UNIT_W-1:0] z;
  } uvec_t;

  typedef struct packed {
    logic signed [WIDE_W-1:0] x;
    logic signed [WIDE_W-1:0] y;
    logic signed [WIDE_W-1:0] z;
  } wvec_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } nrm_stat_t;

  // Q2.30 to Q2.14, magnitude rounded half away from zero
  function automatic logic [OUT_W-1:0] to_q14(logic signed [UNIT_W-1:0] u);
    logic [UNIT_W-1:0] mag;
    logic [OUT_W:0]    rnd;
    mag = u[UNIT_W-1] ? UNIT_W'(-u) : UNIT_W'(u);
    rnd = (OUT_W+1)'((mag + UNIT_W'(32768)) >> 16);
    return u[UNIT_W-1] ? OUT_W'(-rnd) : rnd[OUT_W-1:0];
  endfunction

endpackage

// ===== design/billboard_basis_matrix.sv =====
// ----------------------------------------------------------------------------
// billboard_basis_matrix
// Look-at billboard rotation in Q2.14 from camera eye, target and up.
// ----------------------------------------------------------------------------
// A request is taken on every clock in which start is high; busy never rises,
// so one camera item per cycle is sustained. Each result appears on the row
// ports with done_o high for exactly one cycle, in request order; the
// receiver cannot stall it, so it must sample on that cycle. The path runs
// through three normalisers in series (view axis, right axis, then the true
// up axis with the up-locked third row beside it), each a 31-step square root
// and a 31-step divide at two steps per stage, plus two cross products in
// series and an output stage; the input register loads on the accepting edge itself.
// billboard_mode sits at byte address 0 and may only be changed while no
// request is in flight.
module billboard_basis_matrix (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bbm_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           eye_x_i,
  input  logic signed [31:0]           eye_y_i,
  input  logic signed [31:0]           eye_z_i,
  input  logic signed [31:0]           target_x_i,
  input  logic signed [31:0]           target_y_i,
  input  logic signed [31:0]           target_z_i,
  input  logic signed [31:0]           up_x_i,
  input  logic signed [31:0]           up_y_i,
  input  logic signed [31:0]           up_z_i,
  output logic                         done_o,
  output logic signed [15:0]           row0_x_o,
  output logic signed [15:0]           row0_y_o,
  output logic signed [15:0]           row0_z_o,
  output logic signed [15:0]           row1_x_o,
  output logic signed [15:0]           row1_y_o,
  output logic signed [15:0]           row1_z_o,
  output logic signed [15:0]           row2_x_o,
  output logic signed [15:0]           row2_y_o,
  output logic signed [15:0]           row2_z_o,
  output logic                         degenerate_o
);
  import bbm_pkg::*;

  localparam int unsigned SideLat = CROSS_LAT + NORM_LAT;
  localparam int unsigned AW      = 2 * $bits(uvec_t) + 2;
  localparam int unsigned BW      = 3 * $bits(uvec_t) + 3;

  logic       mode_q;
  logic       mode_sel;
  logic       in_vld_q;
  wvec_t      d_q;
  uvec_t      up_q;
  wvec_t      up_w;

  uvec_t      z_u, upn_u, x_u, y_u, r_u;
  nrm_stat_t  z_st, upn_st, x_st, y_st, r_st;
  uvec_t      up_dly;
  logic       c1_vld, c2_vld, c3_vld;
  wvec_t      c1, c2, c3;

  uvec_t      z_a, upn_a, z_b, upn_b, x_b;
  logic       okz_a, oku_a, okz_b, oku_b, okx_b;
  logic [AW-1:0] dly_a;
  logic [BW-1:0] dly_b;

  uvec_t      row_w [3];
  logic       ok_w;
  logic       done_q;
  logic       deg_q;
  logic [OUT_W-1:0] elem_q [9];

  // configuration port
  assign pready   = 1'b1;
  assign mode_sel = (paddr >> 2) == ADDR_W'(REG_MODE);
  assign prdata   = {31'b0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && mode_sel) begin
      mode_q <= pwdata[0];
    end
  end

  // input stage: view direction and up vector
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      d_q.x <= WIDE_W'((IN_W+1)'(target_x_i) - (IN_W+1)'(eye_x_i));
      d_q.y <= WIDE_W'((IN_W+1)'(target_y_i) - (IN_W+1)'(eye_y_i));
      d_q.z <= WIDE_W'((IN_W+1)'(target_z_i) - (IN_W+1)'(eye_z_i));
      up_q.x <= up_x_i;
      up_q.y <= up_y_i;
      up_q.z <= up_z_i;
    end
  end

  assign up_w.x = WIDE_W'(up_q.x);
  assign up_w.y = WIDE_W'(up_q.y);
  assign up_w.z = WIDE_W'(up_q.z);

  bbm_norm u_norm_z (
    .clk_i, .rst_ni, .valid_i(in_vld_q), .vec_i(d_q), .unit_o(z_u), .stat_o(z_st)
  );

  bbm_norm u_norm_up (
    .clk_i, .rst_ni, .valid_i(in_vld_q), .vec_i(up_w), .unit_o(upn_u), .stat_o(upn_st)
  );

  bbm_delay #(.WIDTH($bits(uvec_t)), .DEPTH(NORM_LAT)) u_dly_up (
    .clk_i, .data_i(up_q), .data_o(up_dly)
  );

  // right axis from up x view
  bbm_cross u_cross_x (
    .clk_i, .rst_ni, .valid_i(z_st.valid), .a_i(up_dly), .b_i(z_u),
    .valid_o(c1_vld), .c_o(c1)
  );

  bbm_norm u_norm_x (
    .clk_i, .rst_ni, .valid_i(c1_vld), .vec_i(c1), .unit_o(x_u), .stat_o(x_st)
  );

  bbm_delay #(.WIDTH(AW), .DEPTH(SideLat)) u_dly_a (
    .clk_i, .data_i({z_u, upn_u, z_st.ok, upn_st.ok}), .data_o(dly_a)
  );
  assign {z_a, upn_a, okz_a, oku_a} = dly_a;

  // true up axis and the up-locked third row
  bbm_cross u_cross_y (
    .clk_i, .rst_ni, .valid_i(x_st.valid), .a_i(z_a), .b_i(x_u),
    .valid_o(c2_vld), .c_o(c2)
  );

  bbm_cross u_cross_r (
    .clk_i, .rst_ni, .valid_i(x_st.valid), .a_i(x_u), .b_i(upn_a),
    .valid_o(c3_vld), .c_o(c3)
  );

  bbm_norm u_norm_y (
    .clk_i, .rst_ni, .valid_i(c2_vld), .vec_i(c2), .unit_o(y_u), .stat_o(y_st)
  );

  bbm_norm u_norm_r (
    .clk_i, .rst_ni, .valid_i(c3_vld), .vec_i(c3), .unit_o(r_u), .stat_o(r_st)
  );

  bbm_delay #(.WIDTH(BW), .DEPTH(SideLat)) u_dly_b (
    .clk_i, .data_i({z_a, upn_a, okz_a, oku_a, x_u, x_st.ok}), .data_o(dly_b)
  );
  assign {z_b, upn_b, okz_b, oku_b, x_b, okx_b} = dly_b;

  // output stage
  always_comb begin
    ok_w     = okz_b && okx_b && y_st.ok && (!mode_q || (oku_b && r_st.ok));
    row_w[0] = x_b;
    row_w[1] = mode_q ? upn_b : y_u;
    row_w[2] = mode_q ? r_u : z_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= y_st.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (y_st.valid) begin
      deg_q <= !ok_w;
      for (int r = 0; r < 3; r++) begin
        if (ok_w) begin
          elem_q[r*3+0] <= to_q14(row_w[r].x);
          elem_q[r*3+1] <= to_q14(row_w[r].y);
          elem_q[r*3+2] <= to_q14(row_w[r].z);
        end else begin
          elem_q[r*3+0] <= (r == 0) ? Q14_ONE : '0;
          elem_q[r*3+1] <= (r == 1) ? Q14_ONE : '0;
          elem_q[r*3+2] <= (r == 2) ? Q14_ONE : '0;
        end
      end
    end
  end

  assign done_o       = done_q;
  assign degenerate_o = deg_q;
  assign row0_x_o     = elem_q[0];
  assign row0_y_o     = elem_q[1];
  assign row0_z_o     = elem_q[2];
  assign row1_x_o     = elem_q[3];
  assign row1_y_o     = elem_q[4];
  assign row1_z_o     = elem_q[5];
  assign row2_x_o     = elem_q[6];
  assign row2_y_o     = elem_q[7];
  assign row2_z_o     = elem_q[8];

endmodule

// ===== design/bbm_delay.sv =====
// ----------------------------------------------------------------------------
// bbm_delay
// Fixed-length register line that keeps side data aligned with the
// normaliser and cross-product stages.
// ----------------------------------------------------------------------------
module bbm_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= data_i;
    for (int i = 1; i < DEPTH; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

// ===== design/bbm_cross.sv =====
// ----------------------------------------------------------------------------
// bbm_cross
// Two-stage cross product of 32-bit signed vectors: six products, then
// the three differences.
// ----------------------------------------------------------------------------
module bbm_cross (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  bbm_pkg::uvec_t a_i,
  input  bbm_pkg::uvec_t b_i,
  output logic           valid_o,
  output bbm_pkg::wvec_t c_o
);
  import bbm_pkg::*;

  logic signed [WIDE_W-1:0] prod_q [6];
  wvec_t                    c_q;
  logic [CROSS_LAT-1:0]     vld_q;

  always_ff @(posedge clk_i) begin
    prod_q[0] <= a_i.y * b_i.z;
    prod_q[1] <= a_i.z * b_i.y;
    prod_q[2] <= a_i.z * b_i.x;
    prod_q[3] <= a_i.x * b_i.z;
    prod_q[4] <= a_i.x * b_i.y;
    prod_q[5] <= a_i.y * b_i.x;
    c_q.x     <= prod_q[0] - prod_q[1];
    c_q.y     <= prod_q[2] - prod_q[3];
    c_q.z     <= prod_q[4] - prod_q[5];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CROSS_LAT-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[CROSS_LAT-1];
  assign c_o     = c_q;

endmodule

// ===== design/bbm_norm.sv =====
// ----------------------------------------------------------------------------
// bbm_norm
// Pipelined vector normaliser: sign/magnitude split, leading-one search,
// common shift into [2^29, 2^30), sum of squares, digit-by-digit square
// root and three restoring dividers, giving a Q2.30 unit vector.
// ----------------------------------------------------------------------------
module bbm_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  bbm_pkg::wvec_t     vec_i,
  output bbm_pkg::uvec_t     unit_o,
  output bbm_pkg::nrm_stat_t stat_o
);
  import bbm_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0]             rem;
    logic [ROOT_W-1:0]            root;
    logic [SQ_W-1:0]              rad;
    logic [2:0][NRM_W-1:0]        mn;
    logic [2:0]                   neg;
    logic                         zero;
  } sq_t;

  typedef struct packed {
    logic [ROOT_W-1:0]            div;
    logic [2:0][DREM_W-1:0]       rem;
    logic [2:0][LOW_W-1:0]        low;
    logic [2:0][QUO_W-1:0]        quo;
    logic [2:0]                   neg;
    logic                         zero;
  } dv_t;

  logic signed [WIDE_W-1:0] v     [3];
  logic [WIDE_W-1:0]        abs_w [3];

  logic [MAG_W-1:0] m1_q [3];
  logic [2:0]       neg1_q;

  logic [MAG_W-1:0] or_w;
  logic [WIDE_W-1:0] pad_w;
  logic [2:0]       grp_w;
  logic [MAG_W-1:0] m2_q [3];
  logic [2:0]       neg2_q;
  logic [2:0]       grp2_q;
  logic [7:0]       byte2_q;
  logic             zero2_q;

  logic [2:0]       bit_w;
  logic [MAG_W-1:0] m3_q [3];
  logic [2:0]       neg3_q;
  logic [POS_W-1:0] pos3_q;
  logic             zero3_q;

  logic [NRM_W-1:0] mn4_q [3];
  logic [2:0]       neg4_q;
  logic             zero4_q;

  logic [2*NRM_W-1:0] sq5_q [3];
  logic [NRM_W-1:0]   mn5_q [3];
  logic [2:0]         neg5_q;
  logic               zero5_q;

  sq_t  sq_q [SQRT_STG+1];
  dv_t  dv_q [DIV_STG+1];
  uvec_t unit_q;
  logic  zero_q;
  logic [NORM_LAT-1:0] vld_q;

  assign v[0] = vec_i.x;
  assign v[1] = vec_i.y;
  assign v[2] = vec_i.z;

  // stage 1: sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_w[i] = v[i][WIDE_W-1] ? WIDE_W'(-v[i]) : WIDE_W'(v[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      m1_q[i]   <= abs_w[i][MAG_W-1:0];
      neg1_q[i] <= v[i][WIDE_W-1];
    end
  end

  // stage 2: highest non-zero byte of the or of all magnitudes
  assign or_w  = m1_q[0] | m1_q[1] | m1_q[2];
  assign pad_w = {1'b0, or_w};

  always_comb begin
    grp_w = '0;
    for (int g = 0; g < WIDE_W / 8; g++) begin
      if (|pad_w[g*8 +: 8]) begin
        grp_w = 3'(g);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m2_q    <= m1_q;
    neg2_q  <= neg1_q;
    grp2_q  <= grp_w;
    byte2_q <= pad_w[grp_w*8 +: 8];
    zero2_q <= ~|or_w;
  end

  // stage 3: bit within that byte
  always_comb begin
    bit_w = '0;
    for (int b = 0; b < 8; b++) begin
      if (byte2_q[b]) begin
        bit_w = 3'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m3_q    <= m2_q;
    neg3_q  <= neg2_q;
    pos3_q  <= {grp2_q, bit_w};
    zero3_q <= zero2_q;
  end

  // stage 4: bring the leading one to bit 29, truncating on right shifts
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      mn4_q[i] <= NRM_W'({m3_q[i], NRM_W'(0)} >> ((POS_W+1)'(pos3_q) + 1'b1));
    end
    neg4_q  <= neg3_q;
    zero4_q <= zero3_q;
  end

  // stage 5: squares
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq5_q[i] <= mn4_q[i] * mn4_q[i];
    end
    mn5_q   <= mn4_q;
    neg5_q  <= neg4_q;
    zero5_q <= zero4_q;
  end

  // stage 6: sum of squares feeds the root
  always_ff @(posedge clk_i) begin
    sq_q[0].rem  <= '0;
    sq_q[0].root <= '0;
    sq_q[0].rad  <= SQ_W'(sq5_q[0]) + SQ_W'(sq5_q[1]) + SQ_W'(sq5_q[2]);
    for (int i = 0; i < 3; i++) begin
      sq_q[0].mn[i] <= mn5_q[i];
    end
    sq_q[0].neg  <= neg5_q;
    sq_q[0].zero <= zero5_q;
  end

  // square root, two result bits per stage
  for (genvar g = 0; g < SQRT_STG; g++) begin : g_sqrt
    sq_t              nx;
    logic [REM_W-1:0] rn;
    logic [REM_W-1:0] tr;

    always_comb begin
      nx = sq_q[g];
      rn = '0;
      tr = '0;
      for (int k = 0; k < SQRT_PER; k++) begin
        if (g * SQRT_PER + k < SQRT_STEPS) begin
          rn     = {nx.rem[REM_W-3:0], nx.rad[SQ_W-1 -: 2]};
          tr     = REM_W'({nx.root, 2'b01});
          nx.rad = nx.rad << 2;
          if (rn >= tr) begin
            nx.rem  = rn - tr;
            nx.root = {nx.root[ROOT_W-2:0], 1'b1};
          end else begin
            nx.rem  = rn;
            nx.root = {nx.root[ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[g+1] <= nx;
    end
  end

  // divider setup: dividend is mag * 2^30 plus half the length
  always_ff @(posedge clk_i) begin
    logic [NRM_W+NRM_W:0] num;
    dv_q[0].div <= sq_q[SQRT_STG].root;
    for (int i = 0; i < 3; i++) begin
      num = (2*NRM_W+1)'({sq_q[SQRT_STG].mn[i], NRM_W'(0)})
          + (2*NRM_W+1)'(sq_q[SQRT_STG].root >> 1);
      dv_q[0].rem[i] <= DREM_W'(num[2*NRM_W:LOW_W]);
      dv_q[0].low[i] <= num[LOW_W-1:0];
      dv_q[0].quo[i] <= '0;
    end
    dv_q[0].neg  <= sq_q[SQRT_STG].neg;
    dv_q[0].zero <= sq_q[SQRT_STG].zero;
  end

  // three restoring dividers sharing one divisor, two bits per stage
  for (genvar g = 0; g < DIV_STG; g++) begin : g_div
    dv_t               nx;
    logic [DREM_W-1:0] rn;

    always_comb begin
      nx = dv_q[g];
      rn = '0;
      for (int k = 0; k < DIV_PER; k++) begin
        if (g * DIV_PER + k < DIV_STEPS) begin
          for (int i = 0; i < 3; i++) begin
            rn        = {nx.rem[i][DREM_W-2:0], nx.low[i][LOW_W-1]};
            nx.low[i] = nx.low[i] << 1;
            if (rn >= DREM_W'(nx.div)) begin
              nx.rem[i] = rn - DREM_W'(nx.div);
              nx.quo[i] = {nx.quo[i][QUO_W-2:0], 1'b1};
            end else begin
              nx.rem[i] = rn;
              nx.quo[i] = {nx.quo[i][QUO_W-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[g+1] <= nx;
    end
  end

  // restore signs
  always_ff @(posedge clk_i) begin
    unit_q.x <= dv_q[DIV_STG].neg[0] ? -UNIT_W'(dv_q[DIV_STG].quo[0])
                                     : UNIT_W'(dv_q[DIV_STG].quo[0]);
    unit_q.y <= dv_q[DIV_STG].neg[1] ? -UNIT_W'(dv_q[DIV_STG].quo[1])
                                     : UNIT_W'(dv_q[DIV_STG].quo[1]);
    unit_q.z <= dv_q[DIV_STG].neg[2] ? -UNIT_W'(dv_q[DIV_STG].quo[2])
                                     : UNIT_W'(dv_q[DIV_STG].quo[2]);
    zero_q   <= dv_q[DIV_STG].zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NORM_LAT-2:0], valid_i};
    end
  end

  assign unit_o       = unit_q;
  assign stat_o.valid = vld_q[NORM_LAT-1];
  assign stat_o.ok    = ~zero_q;

endmodule

// ===== design/bbm_checker.sv =====
// ----------------------------------------------------------------------------
// bbm_checker
// Port-level checks on the billboard basis matrix, bound to the top level.
// ----------------------------------------------------------------------------
module bbm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready,
  input logic                        done_o,
  input logic signed [15:0]          row0_x_o,
  input logic signed [15:0]          row0_y_o,
  input logic signed [15:0]          row0_z_o,
  input logic signed [15:0]          row1_x_o,
  input logic signed [15:0]          row1_y_o,
  input logic signed [15:0]          row1_z_o,
  input logic signed [15:0]          row2_x_o,
  input logic signed [15:0]          row2_y_o,
  input logic signed [15:0]          row2_z_o,
  input logic                        degenerate_o
);
  import bbm_pkg::*;

  // degenerate results carry the identity
  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |->
      row0_x_o == Q14_ONE && row0_y_o == 0 && row0_z_o == 0 &&
      row1_x_o == 0 && row1_y_o == Q14_ONE && row1_z_o == 0 &&
      row2_x_o == 0 && row2_y_o == 0 && row2_z_o == Q14_ONE)
    else $error("degenerate result is not the identity");

  // unit components never leave -1.0 .. 1.0
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !degenerate_o |->
      row0_x_o <= Q14_ONE && row0_x_o >= -Q14_ONE &&
      row0_y_o <= Q14_ONE && row0_y_o >= -Q14_ONE &&
      row0_z_o <= Q14_ONE && row0_z_o >= -Q14_ONE &&
      row1_x_o <= Q14_ONE && row1_x_o >= -Q14_ONE &&
      row1_y_o <= Q14_ONE && row1_y_o >= -Q14_ONE &&
      row1_z_o <= Q14_ONE && row1_z_o >= -Q14_ONE &&
      row2_x_o <= Q14_ONE && row2_x_o >= -Q14_ONE &&
      row2_y_o <= Q14_ONE && row2_y_o >= -Q14_ONE &&
      row2_z_o <= Q14_ONE && row2_z_o >= -Q14_ONE)
    else $error("matrix element out of unit range");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  // mode read back follows the last write
  a_mode_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready |=> prdata[0] == $past(pwdata[0]))
    else $error("mode read back does not match write");

  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[31:1] == '0)
    else $error("unused read bits not zero");

endmodule

bind billboard_basis_matrix bbm_checker u_bbm_checker (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for billboard_basis_matrix: camera requests are driven
// in random bursts, each accepted request is predicted in fixed point and
// every done_o result is compared field by field, in order, against the
// oldest prediction. billboard_mode is changed between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic signed [31:0] v[9];  // eye xyz, target xyz, up xyz
  } cam_req_t;

  typedef logic [9:0][15:0] mat_t;  // nine elements, then degenerate

  class basis_scoreboard;
    mat_t   pending[$];
    int     errors;
    int     checked;
    int     degen_seen;
    string  fname[10] = '{"row0_x", "row0_y", "row0_z", "row1_x", "row1_y",
                          "row1_z", "row2_x", "row2_y", "row2_z", "degenerate"};

    function longint unsigned root64(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n   = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // sign-magnitude normalise to a Q2.30 unit; 0 for a zero vector
    function bit unit3(input longint v[3], output longint u[3]);
      longint unsigned m[3];
      longint unsigned mx, sum, len, q;
      bit              neg[3];
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i] < 0;
        m[i]   = neg[i] ? longint'(-v[i]) : v[i];
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return 0;
      while (mx >= (64'd1 << 30)) begin
        mx = mx >> 1;
        for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx = mx << 1;
        for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
      len = root64(sum);
      for (int i = 0; i < 3; i++) begin
        q    = ((m[i] << 30) + (len >> 1)) / len;
        u[i] = neg[i] ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    function void cross3(input longint a[3], input longint b[3], output longint c[3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function logic [15:0] q14(longint x);
      longint unsigned m, r;
      m = x < 0 ? longint'(-x) : x;
      r = (m + (64'd1 << 15)) >> 16;
      if (x < 0) r = -r;
      return r[15:0];
    endfunction

    function void note(cam_req_t rq, bit mode);
      longint d[3], up[3], az[3], ax[3], ay[3], t[3], upn[3], r2[3];
      longint rows[3][3];
      bit     ok;
      mat_t   e;
      for (int i = 0; i < 3; i++) begin
        d[i]  = longint'(rq.v[3+i]) - longint'(rq.v[i]);
        up[i] = rq.v[6+i];
      end
      ok = unit3(d, az);
      if (ok) begin
        cross3(up, az, t);
        ok = unit3(t, ax);
      end
      if (ok) begin
        cross3(az, ax, t);
        ok = unit3(t, ay);
      end
      rows[0] = ax;
      rows[1] = ay;
      rows[2] = az;
      // up-axis mode swaps in the normalised up and the row orthogonal to it
      if (ok && mode) begin
        ok = unit3(up, upn);
        if (ok) begin
          cross3(ax, upn, t);
          ok = unit3(t, r2);
        end
        rows[1] = upn;
        rows[2] = r2;
      end
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          e[r*3+c] = ok ? q14(rows[r][c]) : (r == c ? 16'd16384 : 16'd0);
      e[9] = ok ? 16'd0 : 16'd1;
      pending.push_back(e);
    endfunction

    function void check(mat_t got);
      mat_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e[9] != 0) degen_seen++;
      for (int i = 0; i < 10; i++)
        if (got[i] !== e[i]) begin
          $display("%0t: %s expected %0d actual %0d", $time, fname[i],
                   $signed(e[i]), $signed(got[i]));
          errors++;
        end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [1:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 0;
  logic               busy;
  logic signed [31:0] fld[9] = '{default: '0};
  logic               done_o, degenerate_o;
  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

  bit                 cur_mode;
  int                 sent;
  basis_scoreboard    sb = new();

  always #5 clk_i = ~clk_i;

  billboard_basis_matrix dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy,
    .eye_x_i(fld[0]), .eye_y_i(fld[1]), .eye_z_i(fld[2]),
    .target_x_i(fld[3]), .target_y_i(fld[4]), .target_z_i(fld[5]),
    .up_x_i(fld[6]), .up_y_i(fld[7]), .up_z_i(fld[8]),
    .done_o,
    .row0_x_o(r00), .row0_y_o(r01), .row0_z_o(r02),
    .row1_x_o(r10), .row1_y_o(r11), .row1_z_o(r12),
    .row2_x_o(r20), .row2_y_o(r21), .row2_z_o(r22),
    .degenerate_o
  );

  always @(posedge clk_i) begin
    cam_req_t rq;
    if (rst_ni && start && !busy) begin
      for (int i = 0; i < 9; i++) rq.v[i] = fld[i];
      sb.note(rq, cur_mode);
    end
    if (rst_ni && done_o)
      sb.check({15'd0, degenerate_o, r22, r21, r20, r12, r11, r10, r02, r01, r00});
  end

  task automatic send_request(cam_req_t rq);
    start <= 1'b1;
    for (int i = 0; i < 9; i++) fld[i] <= rq.v[i];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(bbm_pkg::REG_MODE * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    cur_mode = val[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [31:0] corner();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic cam_req_t rand_request();
    cam_req_t rq;
    int       k;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) rq.v[i] = $urandom;
    case (k)
      4, 5: begin
        for (int i = 0; i < 6; i++) rq.v[i] = $signed($urandom_range(0, 2097151)) - 1048576;
        for (int i = 6; i < 9; i++) rq.v[i] = $signed($urandom_range(0, 262143)) - 131072;
      end
      6: for (int i = 0; i < 3; i++) rq.v[3+i] = rq.v[i];
      7: for (int i = 6; i < 9; i++) rq.v[i] = 0;
      8: begin
        // up parallel to the view direction
        int m;
        m = $urandom_range(0, 1) ? $urandom_range(1, 3) : -1;
        for (int i = 0; i < 3; i++) begin
          logic signed [31:0] dd;
          dd          = $signed($urandom_range(0, 2000)) - 1000;
          rq.v[i]     = $signed($urandom_range(0, 65535)) - 32768;
          rq.v[3+i]   = rq.v[i] + dd;
          rq.v[6+i]   = dd * m;
        end
      end
      9: for (int i = 0; i < 9; i++) rq.v[i] = corner();
      default: ;
    endcase
    return rq;
  endfunction

  task automatic directed_set();
    cam_req_t rq;
    rq.v = '{0, 0, 0, 0, 0, 65536, 0, 65536, 0};
    send_request(rq);
    rq.v = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
             32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000};
    send_request(rq);
    rq.v = '{32'sh7fff_ffff, 0, 32'sh8000_0000, 32'sh8000_0000, 0, 32'sh7fff_ffff,
             32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    send_request(rq);
    rq.v = '{5, 5, 5, 5, 5, 5, 0, 65536, 0};              // target on the eye
    send_request(rq);
    rq.v = '{0, 0, 0, 0, 0, 65536, 0, 0, 0};              // zero up
    send_request(rq);
    rq.v = '{0, 0, 0, 0, 65536, 0, 0, 65536, 0};          // up along the view axis
    send_request(rq);
    rq.v = '{0, 0, 0, 0, 0, -1, 0, -1, 0};
    send_request(rq);
    rq.v = '{0, 0, 0, 1, 0, 0, 32'sh8000_0000, 0, 1};
    send_request(rq);
    rq.v = '{-1, -1, -1, 0, 0, 0, 1, -1, 1};
    send_request(rq);
    rq.v = '{0, 0, 0, 3, 4, 12, 32'sh7fff_ffff, 32'sh8000_0000, 0};
    send_request(rq);
  endtask

  task automatic random_phase(int n);
    int left;
    left = n;
    while (left > 0) begin
      int burst;
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) send_request(rand_request());
      left -= burst;
      case ($urandom_range(0, 3))
        0: ;
        1: pause($urandom_range(1, 3));
        2: pause($urandom_range(4, 20));
        default: pause($urandom_range(100, 140));
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_set();
    drain();
    write_mode(32'h0000_0001);
    directed_set();
    random_phase(350);
    drain();
    write_mode(32'hffff_fffe);   // only bit 0 counts
    random_phase(350);
    drain();
    write_mode(32'hffff_ffff);
    random_phase(350);
    drain();
    write_mode(32'h0000_0000);
    random_phase(350);
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    $display("%0d camera requests sent, %0d matrices checked, %0d degenerate",
             sent, sb.checked, sb.degen_seen);
    $display("both billboard modes, field extremes and zero-length cases exercised");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
